[rtl/core/h2r_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

	localparam int CH_W = 5;
	localparam int REGION_SIZE = 6;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [2*CH_W-1:0] prod_t;

	localparam chan_t CH_MAX = chan_t'(31);

	typedef enum logic [2:0] {
		REG_RED_YEL  = 3'd0,
		REG_YEL_GRN  = 3'd1,
		REG_GRN_CYN  = 3'd2,
		REG_CYN_BLU  = 3'd3,
		REG_BLU_MAG  = 3'd4,
		REG_MAG_RED  = 3'd5
	} region_t;

	// hue / 6 for 5-bit hue: (hue * 11) >> 6 is exact over 0..31
	function automatic region_t region_of(input chan_t hue);
		logic [CH_W+3:0] prod;
		prod = {4'd0, hue} * (CH_W+4)'(11);
		return region_t'(prod[CH_W+3:6]);
	endfunction

	// (hue mod 6) * 6
	function automatic chan_t frac_of(input chan_t hue, input region_t region);
		chan_t reg6;
		chan_t rem;
		reg6 = chan_t'({2'd0, region} * chan_t'(REGION_SIZE));
		rem = hue - reg6;
		return chan_t'(rem * chan_t'(REGION_SIZE));
	endfunction

	// (a * b) >> 5
	function automatic chan_t mul_shr(input chan_t a, input chan_t b);
		prod_t prod;
		prod = {{CH_W{1'b0}}, a} * {{CH_W{1'b0}}, b};
		return prod[2*CH_W-1:CH_W];
	endfunction

endpackage

`default_nettype wire

[rtl/core/hsv_to_rgb_5bit.sv]
`timescale 1ns / 1ps
`default_nettype none

// hsv_to_rgb_5bit: 5-bit HSV to 5-bit RGB conversion, one pixel per clock.
//
// Input channel: hue, saturation and brightness are taken at a rising edge
// where start is high and busy is low. busy is always low: the pipeline
// accepts a transfer on every cycle.
// Output channel: red, green and blue are valid for exactly one cycle while
// done is high. The receiver has no way to stall, so no backpressure exists.
// Results appear with done high after three pipeline stages plus the
// output register.
// Throughput: one transfer per clock. The 5x5 multipliers sit in stages 2
// and 3: one per shade q and t in stage 2, one per shade in stage 3.
// Stages:
//   s1  region = hue/6 (reciprocal multiply), fraction f = (hue mod 6)*6
//   s2  losses s*f>>5 and s*(31-f)>>5
//   s3  shades p, q, t = v*(31-loss)>>5
//   out six-way channel selection, grey bypass when saturation is zero
// Reset: arst_n clears all valid bits asynchronously; data registers are
// not reset, and done stays low until a new transfer reaches the end.
module hsv_to_rgb_5bit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire h2r_pkg::chan_t hue,
	input  wire h2r_pkg::chan_t saturation,
	input  wire h2r_pkg::chan_t brightness,
	output logic                done,
	output h2r_pkg::chan_t      red,
	output h2r_pkg::chan_t      green,
	output h2r_pkg::chan_t      blue
);
	import h2r_pkg::*;

	logic    vld_s1, vld_s2, vld_s3, done_q;
	region_t region_s1, region_s2, region_s3;
	chan_t   frac_s1;
	chan_t   sat_s1, sat_s2;
	chan_t   val_s1, val_s2, val_s3;
	logic    grey_s1, grey_s2, grey_s3;
	chan_t   loss_q_s2, loss_t_s2;
	chan_t   p_s3, q_s3, t_s3;
	chan_t   red_q, green_q, blue_q;
	region_t region_in;
	chan_t   r_nxt, g_nxt, b_nxt;

	assign busy = 1'b0;
	assign region_in = region_of(hue);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// data path, no reset
	always_ff @(posedge clk) begin
		// s1: hue split
		region_s1 <= region_in;
		frac_s1   <= frac_of(hue, region_in);
		sat_s1    <= saturation;
		val_s1    <= brightness;
		grey_s1   <= (saturation == '0);
		// s2: losses for q and t; p uses saturation directly
		region_s2 <= region_s1;
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;
		grey_s2   <= grey_s1;
		loss_q_s2 <= mul_shr(sat_s1, frac_s1);
		loss_t_s2 <= mul_shr(sat_s1, CH_MAX - frac_s1);
		// s3: shades
		region_s3 <= region_s2;
		val_s3    <= val_s2;
		grey_s3   <= grey_s2;
		p_s3      <= mul_shr(val_s2, CH_MAX - sat_s2);
		q_s3      <= mul_shr(val_s2, CH_MAX - loss_q_s2);
		t_s3      <= mul_shr(val_s2, CH_MAX - loss_t_s2);
		// output register
		red_q     <= r_nxt;
		green_q   <= g_nxt;
		blue_q    <= b_nxt;
	end

	// region select, grey overrides
	always_comb begin
		r_nxt = val_s3;
		g_nxt = val_s3;
		b_nxt = val_s3;
		if (!grey_s3) begin
			unique case (region_s3)
				REG_RED_YEL: begin
					r_nxt = val_s3; g_nxt = t_s3;   b_nxt = p_s3;
				end
				REG_YEL_GRN: begin
					r_nxt = q_s3;   g_nxt = val_s3; b_nxt = p_s3;
				end
				REG_GRN_CYN: begin
					r_nxt = p_s3;   g_nxt = val_s3; b_nxt = t_s3;
				end
				REG_CYN_BLU: begin
					r_nxt = p_s3;   g_nxt = q_s3;   b_nxt = val_s3;
				end
				REG_BLU_MAG: begin
					r_nxt = t_s3;   g_nxt = p_s3;   b_nxt = val_s3;
				end
				default: begin
					r_nxt = val_s3; g_nxt = p_s3;   b_nxt = q_s3;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule

`default_nettype wire

[sim/hsv_to_rgb_5bit_tb.sv]
`timescale 1ns / 1ps

module hsv_to_rgb_5bit_tb;

	import h2r_pkg::*;

	// One expected output pixel
	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	// Holds the RGB pixels still owed by the block, oldest first, and
	// predicts each one from the HSV triple at the moment it is accepted.
	class hsv_pixel_checker;
		rgb_t pending_rgb[$];
		int   mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Integer HSV to RGB on 5-bit channels
		function rgb_t convert_pixel(chan_t h, chan_t s, chan_t v);
			int      frac;
			int      p;
			int      q;
			int      t;
			region_t region;
			rgb_t    px;
			if (s == 0) begin
				// grey: hue plays no part
				px.r = v;
				px.g = v;
				px.b = v;
				return px;
			end
			// hues 30 and 31 land in the last region
			region = (h / 6 >= 5) ? REG_MAG_RED : region_t'(h / 6);
			frac = (h % 6) * 6;
			p = (v * (31 - s)) >> 5;
			q = (v * (31 - ((s * frac) >> 5))) >> 5;
			t = (v * (31 - ((s * (31 - frac)) >> 5))) >> 5;
			case (region)
				REG_RED_YEL: begin
					px.r = v;           px.g = chan_t'(t); px.b = chan_t'(p);
				end
				REG_YEL_GRN: begin
					px.r = chan_t'(q);  px.g = v;          px.b = chan_t'(p);
				end
				REG_GRN_CYN: begin
					px.r = chan_t'(p);  px.g = v;          px.b = chan_t'(t);
				end
				REG_CYN_BLU: begin
					px.r = chan_t'(p);  px.g = chan_t'(q); px.b = v;
				end
				REG_BLU_MAG: begin
					px.r = chan_t'(t);  px.g = chan_t'(p); px.b = v;
				end
				default: begin
					px.r = v;           px.g = chan_t'(p); px.b = chan_t'(q);
				end
			endcase
			return px;
		endfunction

		function void note_pixel(chan_t h, chan_t s, chan_t v);
			pending_rgb.push_back(convert_pixel(h, s, v));
		endfunction

		function void check_rgb(chan_t r, chan_t g, chan_t b);
			rgb_t want;
			if (pending_rgb.size() == 0) begin
				$error("unexpected result: red=%0d green=%0d blue=%0d", r, g, b);
				mismatches++;
				return;
			end
			want = pending_rgb.pop_front();
			if (r !== want.r) begin
				$error("red: expected %0d, got %0d", want.r, r);
				mismatches++;
			end
			if (g !== want.g) begin
				$error("green: expected %0d, got %0d", want.g, g);
				mismatches++;
			end
			if (b !== want.b) begin
				$error("blue: expected %0d, got %0d", want.b, b);
				mismatches++;
			end
		endfunction

		function int owed();
			return pending_rgb.size();
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	chan_t hue;
	chan_t saturation;
	chan_t brightness;
	logic  done;
	chan_t red;
	chan_t green;
	chan_t blue;

	hsv_pixel_checker pixels = new();

	hsv_to_rgb_5bit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Input side: a transfer happens at an edge with start high and busy low.
	// Both monitors sample at the edge, before any of that edge's updates land.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pixels.note_pixel(hue, saturation, brightness);
	end

	// Output side: done marks one result for exactly one cycle, no stall
	always @(posedge clk) begin
		if (arst_n && done)
			pixels.check_rgb(red, green, blue);
	end

	// Present one HSV triple, idling first with the given odds (percent).
	// Returns right after the edge at which the transfer took place.
	task automatic send_pixel(input chan_t h, input chan_t s, input chan_t v,
			input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			// idle cycle: junk on the fields must be ignored
			start      <= 1'b0;
			hue        <= chan_t'($urandom);
			saturation <= chan_t'($urandom);
			brightness <= chan_t'($urandom);
			@(posedge clk);
		end
		start      <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Random triple; saturation zero (grey) is forced now and then
	task automatic send_random(input int idle_pct);
		chan_t s;
		s = ($urandom_range(7) == 0) ? chan_t'(0) : chan_t'($urandom);
		send_pixel(chan_t'($urandom), s, chan_t'($urandom), idle_pct);
	endtask

	initial begin
		int n;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		hue        <= '0;
		saturation <= '0;
		brightness <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: grey, every region at both fraction ends, top hues, extremes
		send_pixel(5'd0,  5'd0,  5'd0,  8);
		send_pixel(5'd31, 5'd0,  5'd31, 8);
		send_pixel(5'd17, 5'd0,  5'd13, 8);
		send_pixel(5'd0,  5'd31, 5'd31, 8);
		send_pixel(5'd5,  5'd31, 5'd31, 8);
		send_pixel(5'd6,  5'd31, 5'd31, 8);
		send_pixel(5'd11, 5'd31, 5'd31, 8);
		send_pixel(5'd12, 5'd31, 5'd31, 8);
		send_pixel(5'd17, 5'd31, 5'd31, 8);
		send_pixel(5'd18, 5'd31, 5'd31, 8);
		send_pixel(5'd23, 5'd31, 5'd31, 8);
		send_pixel(5'd24, 5'd31, 5'd31, 8);
		send_pixel(5'd29, 5'd31, 5'd31, 8);
		send_pixel(5'd30, 5'd31, 5'd31, 8);
		send_pixel(5'd31, 5'd31, 5'd31, 8);
		send_pixel(5'd31, 5'd1,  5'd31, 8);
		send_pixel(5'd3,  5'd1,  5'd1,  8);
		send_pixel(5'd0,  5'd31, 5'd0,  8);
		send_pixel(5'd15, 5'd16, 5'd31, 8);
		send_pixel(5'd31, 5'd31, 5'd0,  8);
		send_pixel(5'd20, 5'd7,  5'd22, 8);

		// Random: light idling, then heavy, then back to back
		repeat (350) send_random(8);
		repeat (350) send_random(74);
		repeat (350) send_random(0);
		start <= 1'b0;

		// Drain: wait while results are still owed, allowing plenty of time, then
		// keep the clock running to catch any stray done
		for (n = 0; n < 100 && pixels.owed() > 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (pixels.mismatches == 0 && pixels.owed() == 0) begin
			$display("CHECK OK");
		end else begin
			if (pixels.owed() > 0)
				$error("%0d results never arrived", pixels.owed());
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/h2r_pkg.sv
rtl/core/hsv_to_rgb_5bit.sv
sim/hsv_to_rgb_5bit_tb.sv
